// ----- sv/assert_macros.svh -----
// Assertion macros used by the RTL module of the frame checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/hsfc_pkg.sv -----
// Package with the types, constants and CRC function of the frame checker.
package hsfc_pkg;

  localparam int unsigned AgeBitsDefault = 16;
  localparam int unsigned WinW           = 16;
  localparam int unsigned TempW          = 15;
  localparam int unsigned HumW           = 14;

  localparam logic [7:0]      CrcInit     = 8'hff;
  localparam logic [7:0]      CrcPoly     = 8'h31;
  localparam logic [WinW-1:0] WindowReset = 16'd1000;

  // Fixed-point conversion: value = ((scale * raw) >> 16), minus the offset for temperature.
  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [15:0] TempOffset = 16'd4500;
  localparam logic [13:0] HumScale   = 14'd10000;

  typedef enum logic [1:0] {
    ActReplyByte = 2'd0,
    ActTick      = 2'd1,
    ActRead      = 2'd2,
    ActUnused    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusCrcErr = 2'd1,
    StatusNoData = 2'd2
  } status_e;

  typedef enum logic {
    KindFrame = 1'b0,
    KindRead  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    PosTempHi  = 3'd0,
    PosTempLo  = 3'd1,
    PosTempCrc = 3'd2,
    PosHumHi   = 3'd3,
    PosHumLo   = 3'd4,
    PosHumCrc  = 3'd5
  } byte_pos_e;

  // CRC-8, MSB first, no reflection and no final xor, over one byte.
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/humidity_sensor_frame_checker_core.sv -----
// Frame checker, converter and result cache for a temperature/humidity sensor reply.
// A result is registered on the output in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; input stalls only while a held result is stalled.
// The CRC of each byte is resolved combinationally, and each raw word is converted as it completes.
// Reset (asynchronous, active low) empties the output, clears the cache and rearms the frame.
// After reset the freshness window is 1000 ticks and no cached value is valid.
module humidity_sensor_frame_checker_core #(
  parameter int unsigned AGE_BITS = hsfc_pkg::AgeBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: the freshness window in millisecond ticks.
  input  logic                        cfg_we_i,
  input  logic [hsfc_pkg::WinW-1:0]   cfg_wdata_i,
  // Input channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic                        frame_start_i,
  input  logic [7:0]                  data_byte_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_kind_o,
  output logic [1:0]                  status_o,
  output logic signed [hsfc_pkg::TempW-1:0] temperature_centi_o,
  output logic [hsfc_pkg::HumW-1:0]   humidity_centi_o,
  output logic                        fresh_o
);

  `include "assert_macros.svh"

  localparam int unsigned TempW = hsfc_pkg::TempW;
  localparam int unsigned HumW  = hsfc_pkg::HumW;
  localparam int unsigned WinW  = hsfc_pkg::WinW;
  // Width in which the age and the window are compared.
  localparam int unsigned CmpW  = (AGE_BITS > WinW) ? AGE_BITS : WinW;

  // Configuration register.
  logic [WinW-1:0] window_q;

  // Frame assembly state.
  hsfc_pkg::byte_pos_e pos_q, pos_d, pos_eff;
  logic [7:0]          crc_q, crc_d;
  logic [7:0]          word_hi_q, word_hi_d;
  logic                temp_good_q, temp_good_d;
  // Converted words held until the frame's last CRC byte decides about them.
  logic signed [TempW-1:0] temp_hold_q, temp_hold_d;
  logic [HumW-1:0]         hum_hold_q, hum_hold_d;

  // Cache.
  logic signed [TempW-1:0] cache_temp_q, cache_temp_d;
  logic [HumW-1:0]         cache_hum_q, cache_hum_d;
  logic                    cache_valid_q, cache_valid_d;
  logic [AGE_BITS-1:0]     age_q, age_d;

  // Output register.
  logic                    out_valid_q;
  logic                    res_kind_q, res_kind_d;
  hsfc_pkg::status_e       res_status_q, res_status_d;
  logic signed [TempW-1:0] res_temp_q;
  logic [HumW-1:0]         res_hum_q;
  logic                    res_fresh_q, res_fresh_d;
  logic                    emit;

  logic                    accept;
  logic                    out_load;
  hsfc_pkg::action_e       action;
  logic [15:0]             raw_word;
  logic [30:0]             temp_prod;
  logic [29:0]             hum_prod;
  logic [15:0]             temp_conv;
  logic                    hum_crc_ok;

  // The input is held back only while a finished result waits and is itself stalled.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_load;
  assign accept     = in_valid_i && out_load;
  assign action     = hsfc_pkg::action_e'(action_i);

  // Raw word and its conversion: one multiplier for each word, used on its low byte.
  assign raw_word  = {word_hi_q, data_byte_i};
  assign temp_prod = 31'(hsfc_pkg::TempScale) * 31'(raw_word);
  assign hum_prod  = 30'(hsfc_pkg::HumScale) * 30'(raw_word);
  assign temp_conv = {1'b0, temp_prod[30:16]} - hsfc_pkg::TempOffset;

  assign hum_crc_ok = (crc_q == data_byte_i);

  // A frame start, or a position that cannot arise, restarts at the first byte.
  always_comb begin
    if (frame_start_i || (pos_q > hsfc_pkg::PosHumCrc)) begin
      pos_eff = hsfc_pkg::PosTempHi;
    end else begin
      pos_eff = pos_q;
    end
  end

  always_comb begin
    logic [CmpW-1:0] age_ext;
    logic [CmpW-1:0] win_ext;

    pos_d         = pos_q;
    crc_d         = crc_q;
    word_hi_d     = word_hi_q;
    temp_good_d   = temp_good_q;
    temp_hold_d   = temp_hold_q;
    hum_hold_d    = hum_hold_q;
    cache_temp_d  = cache_temp_q;
    cache_hum_d   = cache_hum_q;
    cache_valid_d = cache_valid_q;
    age_d         = age_q;
    emit          = 1'b0;
    res_kind_d    = hsfc_pkg::KindFrame;
    res_status_d  = hsfc_pkg::StatusOk;

    age_ext = CmpW'(age_q);
    win_ext = CmpW'(window_q);

    if (accept) begin
      unique case (action)
        hsfc_pkg::ActTick: begin
          // Ageing saturates at the window or at the counter's full scale.
          if ((age_ext < win_ext) && (age_q != '1)) begin
            age_d = age_q + 1'b1;
          end
        end
        hsfc_pkg::ActRead: begin
          emit         = 1'b1;
          res_kind_d   = hsfc_pkg::KindRead;
          res_status_d = cache_valid_q ? hsfc_pkg::StatusOk : hsfc_pkg::StatusNoData;
        end
        hsfc_pkg::ActReplyByte: begin
          unique case (pos_eff)
            hsfc_pkg::PosTempHi, hsfc_pkg::PosHumHi: begin
              crc_d     = hsfc_pkg::crc8_byte(hsfc_pkg::CrcInit, data_byte_i);
              word_hi_d = data_byte_i;
              pos_d     = hsfc_pkg::byte_pos_e'(pos_eff + 3'd1);
            end
            hsfc_pkg::PosTempLo: begin
              crc_d       = hsfc_pkg::crc8_byte(crc_q, data_byte_i);
              temp_hold_d = temp_conv[TempW-1:0];
              pos_d       = hsfc_pkg::PosTempCrc;
            end
            hsfc_pkg::PosHumLo: begin
              crc_d      = hsfc_pkg::crc8_byte(crc_q, data_byte_i);
              hum_hold_d = hum_prod[29:16];
              pos_d      = hsfc_pkg::PosHumCrc;
            end
            hsfc_pkg::PosTempCrc: begin
              temp_good_d = hum_crc_ok;
              crc_d       = hsfc_pkg::CrcInit;
              pos_d       = hsfc_pkg::PosHumHi;
            end
            default: begin
              // Last byte: both checks decide whether the cache takes the frame.
              crc_d      = hsfc_pkg::CrcInit;
              pos_d      = hsfc_pkg::PosTempHi;
              emit       = 1'b1;
              res_kind_d = hsfc_pkg::KindFrame;
              if (temp_good_q && hum_crc_ok) begin
                cache_temp_d  = temp_hold_q;
                cache_hum_d   = hum_hold_q;
                cache_valid_d = 1'b1;
                age_d         = '0;
                res_status_d  = hsfc_pkg::StatusOk;
              end else begin
                res_status_d  = hsfc_pkg::StatusCrcErr;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    // Results show the cache as it stands once this transaction has been applied.
    res_fresh_d = cache_valid_d && (CmpW'(age_d) < win_ext);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q      <= hsfc_pkg::WindowReset;
      pos_q         <= hsfc_pkg::PosTempHi;
      crc_q         <= hsfc_pkg::CrcInit;
      temp_good_q   <= 1'b0;
      cache_valid_q <= 1'b0;
      age_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      pos_q         <= pos_d;
      crc_q         <= crc_d;
      temp_good_q   <= temp_good_d;
      cache_valid_q <= cache_valid_d;
      age_q         <= age_d;
      if (out_load) begin
        out_valid_q <= emit;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    word_hi_q    <= word_hi_d;
    temp_hold_q  <= temp_hold_d;
    hum_hold_q   <= hum_hold_d;
    cache_temp_q <= cache_temp_d;
    cache_hum_q  <= cache_hum_d;
    if (out_load && emit) begin
      res_kind_q   <= res_kind_d;
      res_status_q <= res_status_d;
      res_temp_q   <= cache_valid_d ? cache_temp_d : '0;
      res_hum_q    <= cache_valid_d ? cache_hum_d : '0;
      res_fresh_q  <= res_fresh_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = res_kind_q;
  assign status_o            = res_status_q;
  assign temperature_centi_o = res_temp_q;
  assign humidity_centi_o    = res_hum_q;
  assign fresh_o             = res_fresh_q;

  `ASSERT_ALWAYS(a_pos_in_range, pos_q <= hsfc_pkg::PosHumCrc, "byte position beyond frame")
  `ASSERT_IMPLIES(a_fresh_has_data, out_valid_q && res_fresh_q,
                  res_status_q != hsfc_pkg::StatusNoData, "fresh result without data")
  `ASSERT_IMPLIES(a_ok_frame_cached,
                  out_valid_q && (res_kind_q == hsfc_pkg::KindFrame) &&
                  (res_status_q == hsfc_pkg::StatusOk),
                  cache_valid_q, "good frame left cache invalid")
  `ASSERT_IMPLIES(a_nodata_zero, out_valid_q && (res_status_q == hsfc_pkg::StatusNoData),
                  (res_temp_q == '0) && (res_hum_q == '0), "values shown without data")

endmodule
